@@ rtl/trilinear_volume_sampler_macros.svh @@
// Assertion macros shared by the trilinear volume sampler RTL.
`ifndef TRILINEAR_VOLUME_SAMPLER_MACROS_SVH
`define TRILINEAR_VOLUME_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TVS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trilinear_volume_sampler: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trilinear_volume_sampler: next-cycle check failed");

`endif

@@ rtl/tvs_pkg.sv @@
// Shared constants and types of the trilinear volume sampler.
package tvs_pkg;

   localparam int DIM_BITS_DEFAULT = 6;

   localparam int POS_W     = 14;
   localparam int FRAC_W    = 8;
   localparam int CELL_W    = 6;
   localparam int SIZE_W    = 7;
   localparam int SXY_W     = 14;
   localparam int VADDR_W   = 18;
   localparam int VOXEL_W   = 8;
   localparam int VALUE_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Linear corner address before wrapping to the store depth.
   localparam int LIN_W   = 21;
   localparam int W_W     = FRAC_W + 1;
   localparam int WXY_W   = 2 * FRAC_W + 1;
   localparam int TERM1_W = VOXEL_W + WXY_W;
   // The weights sum to 2^24, so every partial and total sum fits 32 bits.
   localparam int SUM_W   = 32;

   localparam int NUM_STAGES = 8;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
   localparam logic [SXY_W-1:0]  SXY_RESET  = SXY_W'(4096);

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = CSR_IDX_W'(2);

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef logic [LIN_W-1:0] lin_type;
   typedef logic [SUM_W-1:0] sum_type;

endpackage

@@ rtl/tvs_req_if.sv @@
// Request channel: voxel loads and sample requests.
interface tvs_req_if import tvs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [VADDR_W-1:0] voxel_address;
   logic [VOXEL_W-1:0] voxel_value;
   logic [POS_W-1:0]   pos_x;
   logic [POS_W-1:0]   pos_y;
   logic [POS_W-1:0]   pos_z;

   modport source (output valid, kind, voxel_address, voxel_value, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, kind, voxel_address, voxel_value, pos_x, pos_y, pos_z,
                 output ready);
endinterface

@@ rtl/tvs_rsp_if.sv @@
// Response channel: interpolated samples.
interface tvs_rsp_if import tvs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] sample_value;
   logic               out_of_range;

   modport source (output valid, sample_value, out_of_range, input ready);
   modport sink (input valid, sample_value, out_of_range, output ready);
endinterface

@@ rtl/tvs_csr_if.sv @@
// Register write channel for the volume size registers.
interface tvs_csr_if import tvs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SIZE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/tvs_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module tvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/trilinear_volume_sampler.sv @@
// A sample accepted on req passes through the stage registers and is presented on rsp.
// Throughput: one item per cycle while rsp is ready; the eight corners come from four
// copies of the voxel store, each read at two addresses per cycle. Loads give no response.
// Reset (synchronous): all stage valid bits clear and the sizes return to 64.
// The voxel store is not cleared; its contents are undefined until loaded.
`include "trilinear_volume_sampler_macros.svh"

module trilinear_volume_sampler import tvs_pkg::*; #(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   tvs_req_if.sink   req_port,
   tvs_rsp_if.source rsp_port,
   tvs_csr_if.sink   csr_port
);

   localparam int ADDR_W = 3 * DIM_BITS;
   localparam int DEPTH  = 2 ** ADDR_W;

   // Size registers and the derived plane size.
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SXY_W-1:0]  sxy_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
         sxy_ff    <= SXY_RESET;
      end else begin
         sxy_ff <= SXY_W'(size_x_ff) * SXY_W'(size_y_ff);
         if (csr_port.valid) begin
            unique case (csr_port.index)
               CSR_SIZE_X: size_x_ff <= csr_port.data;
               CSR_SIZE_Y: size_y_ff <= csr_port.data;
               CSR_SIZE_Z: size_z_ff <= csr_port.data;
               default: ;
            endcase
         end
      end
   end

   // Stage valid bits and the backpressure chain.
   logic [NUM_STAGES:1] vld_ff, vld_in, rdy;

   always_comb begin
      rdy[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp_port.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_port.ready = rdy[1];

   // Stage 1: registered request.
   logic               s1_kind_ff;
   logic [VADDR_W-1:0] s1_vaddr_ff;
   logic [VOXEL_W-1:0] s1_vval_ff;
   logic [POS_W-1:0]   s1_px_ff, s1_py_ff, s1_pz_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_kind_ff  <= req_port.kind;
         s1_vaddr_ff <= req_port.voxel_address;
         s1_vval_ff  <= req_port.voxel_value;
         s1_px_ff    <= req_port.pos_x;
         s1_py_ff    <= req_port.pos_y;
         s1_pz_ff    <= req_port.pos_z;
      end
   end

   logic [CELL_W-1:0] ix1, iy1, iz1;
   logic              s2_oor_in;
   lin_type           s2_zterm_in, s2_yterm_in;

   always_comb begin
      ix1 = s1_px_ff[POS_W-1:FRAC_W];
      iy1 = s1_py_ff[POS_W-1:FRAC_W];
      iz1 = s1_pz_ff[POS_W-1:FRAC_W];
      // The upper neighbor must lie inside the volume on every axis.
      s2_oor_in = (SIZE_W'(ix1) + SIZE_W'(1) >= size_x_ff) ||
                  (SIZE_W'(iy1) + SIZE_W'(1) >= size_y_ff) ||
                  (SIZE_W'(iz1) + SIZE_W'(1) >= size_z_ff);
      s2_zterm_in = LIN_W'(iz1) * LIN_W'(sxy_ff);
      s2_yterm_in = LIN_W'(iy1) * LIN_W'(size_x_ff);
   end

   // Stage 2: partial address products.
   logic               s2_kind_ff, s2_oor_ff;
   logic [VADDR_W-1:0] s2_vaddr_ff;
   logic [VOXEL_W-1:0] s2_vval_ff;
   lin_type            s2_zterm_ff, s2_yterm_ff;
   logic [CELL_W-1:0]  s2_ix_ff;
   logic [FRAC_W-1:0]  s2_fx_ff, s2_fy_ff, s2_fz_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_oor_ff   <= s2_oor_in;
         s2_vaddr_ff <= s1_vaddr_ff;
         s2_vval_ff  <= s1_vval_ff;
         s2_zterm_ff <= s2_zterm_in;
         s2_yterm_ff <= s2_yterm_in;
         s2_ix_ff    <= ix1;
         s2_fx_ff    <= s1_px_ff[FRAC_W-1:0];
         s2_fy_ff    <= s1_py_ff[FRAC_W-1:0];
         s2_fz_ff    <= s1_pz_ff[FRAC_W-1:0];
      end
   end

   // Stage 3: base address of the lower corner.
   logic               s3_kind_ff, s3_oor_ff;
   logic [VADDR_W-1:0] s3_vaddr_ff;
   logic [VOXEL_W-1:0] s3_vval_ff;
   lin_type            s3_base_ff;
   logic [FRAC_W-1:0]  s3_fx_ff, s3_fy_ff, s3_fz_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_kind_ff  <= s2_kind_ff;
         s3_oor_ff   <= s2_oor_ff;
         s3_vaddr_ff <= s2_vaddr_ff;
         s3_vval_ff  <= s2_vval_ff;
         s3_base_ff  <= s2_zterm_ff + s2_yterm_ff + LIN_W'(s2_ix_ff);
         s3_fx_ff    <= s2_fx_ff;
         s3_fy_ff    <= s2_fy_ff;
         s3_fz_ff    <= s2_fz_ff;
      end
   end

   // Corner n = x + 2*y + 4*z selects the upper neighbor on each set bit.
   lin_type           corner_lin [8];
   logic [ADDR_W-1:0] corner_addr [8];
   logic [W_W-1:0]    wx [2], wy [2], wz [2];
   logic [WXY_W-1:0]  s4_wxy_in [4];
   logic              ram_we;

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         corner_lin[n] = s3_base_ff + LIN_W'(n % 2)
                       + (((n / 2) % 2 == 1) ? LIN_W'(size_x_ff) : LIN_W'(0))
                       + ((n / 4 == 1) ? LIN_W'(sxy_ff) : LIN_W'(0));
         corner_addr[n] = ADDR_W'(corner_lin[n]);
      end
      wx[0] = W_W'(2 ** FRAC_W) - W_W'(s3_fx_ff);
      wx[1] = W_W'(s3_fx_ff);
      wy[0] = W_W'(2 ** FRAC_W) - W_W'(s3_fy_ff);
      wy[1] = W_W'(s3_fy_ff);
      wz[0] = W_W'(2 ** FRAC_W) - W_W'(s3_fz_ff);
      wz[1] = W_W'(s3_fz_ff);
      for (int m = 0; m < 4; m++) begin
         s4_wxy_in[m] = WXY_W'(wx[m % 2]) * WXY_W'(wy[m / 2]);
      end
   end

   // A load leaves the pipeline when it writes the store.
   assign ram_we = rdy[4] && vld_ff[3] && (s3_kind_ff == KIND_LOAD);

   logic [VOXEL_W-1:0] vox [8];

   for (genvar r = 0; r < 4; r++) begin : g_copy
      tvs_ram #(
         .WIDTH (VOXEL_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock     (clock),
         .wr_en     (ram_we),
         .wr_addr   (ADDR_W'(s3_vaddr_ff)),
         .wr_data   (s3_vval_ff),
         .rd_en     (rdy[4]),
         .rd_addr_a (corner_addr[2*r]),
         .rd_addr_b (corner_addr[2*r+1]),
         .rd_data_a (vox[2*r]),
         .rd_data_b (vox[2*r+1])
      );
   end

   // Stage 4: voxels from the store, weights of the x-y plane.
   logic             s4_oor_ff;
   logic [WXY_W-1:0] s4_wxy_ff [4];
   logic [W_W-1:0]   s4_wz_ff [2];

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_oor_ff <= s3_oor_ff;
         s4_wxy_ff <= s4_wxy_in;
         s4_wz_ff  <= wz;
      end
   end

   logic [TERM1_W-1:0] s5_t_in [8];

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         s5_t_in[n] = TERM1_W'(vox[n]) * TERM1_W'(s4_wxy_ff[n % 4]);
      end
   end

   // Stage 5: voxel times x-y weight.
   logic               s5_oor_ff;
   logic [TERM1_W-1:0] s5_t_ff [8];
   logic [W_W-1:0]     s5_wz_ff [2];

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_oor_ff <= s4_oor_ff;
         s5_t_ff   <= s5_t_in;
         s5_wz_ff  <= s4_wz_ff;
      end
   end

   sum_type s6_term_in [8];

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         s6_term_in[n] = SUM_W'(s5_t_ff[n]) * SUM_W'(s5_wz_ff[n / 4]);
      end
   end

   // Stage 6: full corner terms.
   logic    s6_oor_ff;
   sum_type s6_term_ff [8];

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_oor_ff  <= s5_oor_ff;
         s6_term_ff <= s6_term_in;
      end
   end

   // Stage 7: pair sums.
   logic    s7_oor_ff;
   sum_type s7_pair_ff [4];

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         s7_oor_ff <= s6_oor_ff;
         for (int i = 0; i < 4; i++) begin
            s7_pair_ff[i] <= s6_term_ff[2*i] + s6_term_ff[2*i+1];
         end
      end
   end

   sum_type            total;
   logic [VALUE_W-1:0] rsp_value_in;

   always_comb begin
      total        = s7_pair_ff[0] + s7_pair_ff[1] + s7_pair_ff[2] + s7_pair_ff[3];
      rsp_value_in = s7_oor_ff ? VALUE_W'(0) : total[SUM_W-1:SUM_W-VALUE_W];
   end

   // Stage 8: output register.
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         rsp_value_ff <= rsp_value_in;
         rsp_oor_ff   <= s7_oor_ff;
      end
   end

   always_comb begin
      vld_in[1] = req_port.valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
      vld_in[4] = vld_ff[3] && (s3_kind_ff == KIND_SAMPLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign rsp_port.valid        = vld_ff[NUM_STAGES];
   assign rsp_port.sample_value = rsp_value_ff;
   assign rsp_port.out_of_range = rsp_oor_ff;

   `TVS_ASSERT_IMPLY(a_full_stall, clock, reset,
                     (&vld_ff) && !rsp_port.ready, !req_port.ready)
   `TVS_ASSERT_NEXT(a_load_drops, clock, reset, ram_we, !vld_ff[4])
   `TVS_ASSERT_IMPLY(a_oor_zero, clock, reset,
                     rsp_port.valid && rsp_port.out_of_range, rsp_port.sample_value == '0)

endmodule
